// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/prca_pkg.sv -----
// ---------------------------------------------------------------------------
// prca_pkg
// Types, constants and helper functions of the phase rotating accumulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prca_pkg;

  // Default sizes
  localparam int unsigned FRAME_MAX_DEF    = 1024;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned TRIG_BITS_DEF    = 10;

  // Fixed widths
  localparam int unsigned SUM_W    = 26;   // accumulator word
  localparam int unsigned CNT_W    = 9;    // count_accum / frames added
  localparam int unsigned NUM_W    = CNT_W + 1; // divisor
  localparam int unsigned PHASE_W  = 16;
  localparam int unsigned FLEN_W   = 11;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned TRIG_W   = 16;   // Q1.15 cosine / sine
  localparam int unsigned CORD_W   = 33;   // CORDIC datapath
  localparam int unsigned CORD_N   = 16;   // CORDIC iterations
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 16;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_COUNT_ACCUM  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PHASE_STEP   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FRAME_LENGTH = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0]   COUNT_RST = 9'd1;
  localparam logic [FLEN_W-1:0]  FLEN_RST  = 11'd1024;

  // Per-frame action
  typedef enum logic [1:0] {
    ACT_STORE    = 2'd0,
    ACT_ACCUM    = 2'd1,
    ACT_LAST     = 2'd2,
    ACT_MISMATCH = 2'd3
  } act_e;

  // CORDIC seed (gain compensated unit vector, Q2.30)
  localparam logic signed [CORD_W-1:0] CORD_X0 = 33'sd652032874;

  // Arctangent of 2^-k in units of 2^-32 turn
  function automatic logic signed [CORD_W-1:0] atan_turn(input logic [3:0] k);
    logic signed [CORD_W-1:0] v;
    unique case (k)
      4'd0:  v = 33'sd536870912;
      4'd1:  v = 33'sd316933406;
      4'd2:  v = 33'sd167458907;
      4'd3:  v = 33'sd85004756;
      4'd4:  v = 33'sd42667335;
      4'd5:  v = 33'sd21354465;
      4'd6:  v = 33'sd10679839;
      4'd7:  v = 33'sd5340245;
      4'd8:  v = 33'sd2670163;
      4'd9:  v = 33'sd1335087;
      4'd10: v = 33'sd667544;
      4'd11: v = 33'sd333772;
      4'd12: v = 33'sd166886;
      4'd13: v = 33'sd83443;
      4'd14: v = 33'sd41722;
      default: v = 33'sd20861;
    endcase
    return v;
  endfunction

  // Round Q2.30 to Q1.15 and clamp to +-32767
  function automatic logic signed [TRIG_W-1:0] round_clamp(
      input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W-1:0] r;
    r = (v + 33'sd16384) >>> 15;
    if (r > 33'sd32767) return 16'sd32767;
    if (r < -33'sd32767) return -16'sd32767;
    return r[TRIG_W-1:0];
  endfunction

endpackage

// ----- src/prca_ram.sv -----
// ---------------------------------------------------------------------------
// prca_ram
// Simple dual port RAM, one write and one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- src/prca_div.sv -----
// ---------------------------------------------------------------------------
// prca_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prca_div #(
  parameter int unsigned DVW = 27,  // dividend / quotient width
  parameter int unsigned NW  = 10   // divisor width
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [NW-1:0]  divisor_i,
  output logic [DVW-1:0] quotient_o,
  output logic           done_o
);

  localparam int unsigned CW = $clog2(DVW + 1);

  logic [DVW-1:0] quo_q;
  logic [NW-1:0]  rem_q;
  logic [NW-1:0]  div_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [NW:0]    rem_sh;
  logic           fits;

  // Trial subtract
  assign rem_sh = {rem_q, quo_q[DVW-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= NW'(rem_sh - {1'b0, div_q});
      end else begin
        rem_q <= rem_sh[NW-1:0];
      end
      quo_q <= {quo_q[DVW-2:0], fits};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(DVW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ----- src/phase_rotating_coherent_accumulator.sv -----
// ---------------------------------------------------------------------------
// phase_rotating_coherent_accumulator
// Rotates I/Q frames by a per-frame phase and integrates matching frames.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats on s_axis carry one I/Q sample with azimuth and frame tags.
//   Output beats on m_axis carry a rotated (pass mode) or averaged sample;
//   tlast marks the final sample of an output frame. Store and accumulate
//   frames give no output beat.
//   One sample is in flight at a time. A sample passes through S_MUL, S_ROT
//   and S_ACC from accept to result (or to write back); the first sample of a
//   frame first runs the iterative CORDIC that produces that frame's cos/sin
//   pair, and samples that deliver an average also wait for the two
//   shared-width restoring dividers. The sum memory is read at accept and
//   written back in S_ACC, before the block returns to idle for the next input.
//   Reset clears all control state; the sum memory is not cleared and its
//   read data is only used in frames that follow a stored frame.
//   When the receiver stalls, the result holds in the output register and
//   no new input beat is taken until it leaves.
//   Registers are written through cfg_we_i / cfg_addr_i / cfg_wdata_i; the user
//   must write them only while the block is idle, which the block does not enforce.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module phase_rotating_coherent_accumulator #(
  parameter int unsigned FRAME_MAX       = prca_pkg::FRAME_MAX_DEF,
  parameter int unsigned SAMPLE_WIDTH    = prca_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned TRIG_TABLE_BITS = prca_pkg::TRIG_BITS_DEF,
  localparam int unsigned IN_DW  = ((2 * SAMPLE_WIDTH + 64) + 7) / 8 * 8,
  localparam int unsigned OUT_DW = ((2 * (SAMPLE_WIDTH + 1) + 32) + 7) / 8 * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [prca_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [prca_pkg::CFG_DW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // sample_i, sample_q, azimuth_i, azimuth_q, in_frame_i, in_frame_q
  input  logic [IN_DW-1:0]             s_axis_tdata_i,
  // output stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // out_i, out_q, frame_num_i, frame_num_q
  output logic [OUT_DW-1:0]            m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);

  import prca_pkg::*;

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned RW  = SW + 1;          // rotated sample
  localparam int unsigned PW  = SW + TRIG_W;     // product
  localparam int unsigned AW2 = PW + 1;          // sum of products
  localparam int unsigned TB  = TRIG_TABLE_BITS;
  localparam int unsigned IW  = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
  localparam int unsigned LW  = $clog2(FRAME_MAX + 1) + 1;
  localparam int unsigned DVW = SUM_W + 1;
  localparam int unsigned OPAD = OUT_DW - (2 * RW + 2 * TAG_W);

  typedef enum logic [2:0] {
    S_IDLE, S_TRIG, S_TRIGFIN, S_MUL, S_ROT, S_ACC, S_DIV, S_OUT
  } state_e;

  // Configuration registers
  logic [CNT_W-1:0]   count_q;
  logic [PHASE_W-1:0] pstep_q;
  logic [FLEN_W-1:0]  flen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RST;
      pstep_q <= '0;
      flen_q  <= FLEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_COUNT_ACCUM:  count_q <= cfg_wdata_i[CNT_W-1:0];
        REG_PHASE_STEP:   pstep_q <= cfg_wdata_i[PHASE_W-1:0];
        REG_FRAME_LENGTH: flen_q  <= cfg_wdata_i[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input unpacking
  logic signed [SW-1:0] in_si, in_sq;
  logic [TAG_W-1:0]     in_az_i, in_az_q, in_fr_i, in_fr_q;

  assign in_si   = s_axis_tdata_i[SW-1:0];
  assign in_sq   = s_axis_tdata_i[2*SW-1:SW];
  assign in_az_i = s_axis_tdata_i[2*SW+15:2*SW];
  assign in_az_q = s_axis_tdata_i[2*SW+31:2*SW+16];
  assign in_fr_i = s_axis_tdata_i[2*SW+47:2*SW+32];
  assign in_fr_q = s_axis_tdata_i[2*SW+63:2*SW+48];

  // Block state
  state_e               state_q;
  logic [CNT_W-1:0]     fadd_q;
  logic [IW-1:0]        idx_q;
  logic [TAG_W-1:0]     saz_i_q, saz_q_q;
  logic [PHASE_W-1:0]   phase_q;
  logic [TAG_W-1:0]     fcnt_q;
  act_e                 act_q;

  // Per-sample registers
  logic signed [SW-1:0]     xi_q, xq_q;
  logic [TAG_W-1:0]         fr_i_q, fr_q_q;
  logic                     byp_q, last_q;
  logic [IW-1:0]            slot_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic signed [CORD_W-1:0] cx_q, cy_q, cz_q;
  logic [1:0]               quad_q;
  logic [3:0]               step_q;
  logic signed [PW-1:0]     pic_q, pqs_q, pqc_q, pis_q;
  logic signed [RW-1:0]     ri_q, rq_q;
  logic signed [RW-1:0]     oi_q, oq_q;
  logic [TAG_W-1:0]         fn_i_q, fn_q_q;
  logic                     olast_q;
  logic                     neg_i_q, neg_q_q, nzero_q;

  // Memory
  logic                    ram_we;
  logic [2*SUM_W-1:0]      ram_wdata, ram_rdata;
  logic signed [SUM_W-1:0] mem_i, mem_q;
  logic                    accept;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign mem_i           = ram_rdata[SUM_W-1:0];
  assign mem_q           = ram_rdata[2*SUM_W-1:SUM_W];

  // Frame decision, taken on the first sample of a frame
  logic                 bypass;
  logic                 first;
  act_e                 act_d;
  logic [CNT_W-1:0]     fadd_d;
  logic [PHASE_W-1:0]   phase_d;
  logic                 restart;

  assign bypass = (count_q <= CNT_W'(1));
  assign first  = (idx_q == '0);

  always_comb begin
    act_d   = act_q;
    fadd_d  = fadd_q;
    restart = 1'b0;
    if (first) begin
      if (bypass) begin
        fadd_d = '0;
        act_d  = ACT_STORE;
      end else if (fadd_q == '0) begin
        act_d  = ACT_STORE;
      end else if (in_az_i == saz_i_q && in_az_q == saz_q_q) begin
        act_d = ({1'b0, fadd_q} + NUM_W'(1) >= {1'b0, count_q}) ? ACT_LAST : ACT_ACCUM;
      end else begin
        act_d = ACT_MISMATCH;
      end
      restart = !bypass && (act_d == ACT_STORE);
    end
    phase_d = restart ? '0 : phase_q;
  end

  // Frame end for the accepted sample
  logic [LW-1:0] len;
  logic          last_d;

  always_comb begin
    if (flen_q == '0) begin
      len = LW'(1);
    end else if (LW'(flen_q) > LW'(FRAME_MAX)) begin
      len = LW'(FRAME_MAX);
    end else begin
      len = LW'(flen_q);
    end
  end
  assign last_d = (LW'(idx_q) + LW'(1)) >= len;

  // CORDIC start angle: table entry of the frame phase
  logic [TB-1:0] tidx;
  logic [31:0]   ang, ang_r, rr;
  logic [1:0]    quad0;

  assign tidx  = phase_d[PHASE_W-1 -: TB];
  assign ang   = 32'(tidx) << (32 - TB);
  assign ang_r = ang + 32'h2000_0000;
  assign quad0 = ang_r[31:30];
  assign rr    = ang - (32'(quad0) << 30);

  // CORDIC micro-rotation
  logic signed [CORD_W-1:0] dx, dy, atn;
  assign dx  = cy_q >>> step_q;
  assign dy  = cx_q >>> step_q;
  assign atn = atan_turn(step_q);

  // Quadrant fold of the rounded pair
  logic signed [TRIG_W-1:0] c_r, s_r, c_f, s_f;
  assign c_r = round_clamp(cx_q);
  assign s_r = round_clamp(cy_q);

  always_comb begin
    unique case (quad_q)
      2'd0: begin c_f = c_r;  s_f = s_r;  end
      2'd1: begin c_f = -s_r; s_f = c_r;  end
      2'd2: begin c_f = -c_r; s_f = -s_r; end
      default: begin c_f = s_r; s_f = -c_r; end
    endcase
  end

  // Rotation rounding
  logic signed [AW2-1:0] rsum_i, rsum_q;
  assign rsum_i = AW2'(pic_q) + AW2'(pqs_q) + AW2'(16384);
  assign rsum_q = AW2'(pqc_q) - AW2'(pis_q) + AW2'(16384);

  // Accumulate and average setup
  logic signed [SUM_W-1:0] new_i, new_q, avs_i, avs_q;
  logic [SUM_W-1:0]        mag_i, mag_q;
  logic [NUM_W-1:0]        num;
  logic [DVW-1:0]          dvd_i, dvd_q;

  assign new_i = mem_i + SUM_W'(ri_q);
  assign new_q = mem_q + SUM_W'(rq_q);
  assign avs_i = (act_q == ACT_LAST) ? new_i : mem_i;
  assign avs_q = (act_q == ACT_LAST) ? new_q : mem_q;
  assign num   = (act_q == ACT_LAST) ? ({1'b0, fadd_q} + NUM_W'(1)) : {1'b0, fadd_q};
  assign mag_i = avs_i[SUM_W-1] ? SUM_W'(-avs_i) : SUM_W'(avs_i);
  assign mag_q = avs_q[SUM_W-1] ? SUM_W'(-avs_q) : SUM_W'(avs_q);
  assign dvd_i = {1'b0, mag_i} + DVW'(num >> 1);
  assign dvd_q = {1'b0, mag_q} + DVW'(num >> 1);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {new_q, new_i};
    if (state_q == S_ACC && !byp_q) begin
      unique case (act_q)
        ACT_STORE: begin
          ram_we    = 1'b1;
          ram_wdata = {SUM_W'(rq_q), SUM_W'(ri_q)};
        end
        ACT_ACCUM, ACT_LAST: ram_we = 1'b1;
        default: ;
      endcase
    end
  end

  prca_ram #(
    .WIDTH (2 * SUM_W),
    .DEPTH (FRAME_MAX)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Dividers for the averages, loaded while the frame count is still valid
  logic           div_start;
  logic [DVW-1:0] quo_i, quo_q;
  logic           div_done_i, div_done_q;

  assign div_start = (state_q == S_ACC) && !byp_q &&
                     (act_q == ACT_LAST || act_q == ACT_MISMATCH);

  prca_div #(.DVW(DVW), .NW(NUM_W)) u_div_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_i),
    .divisor_i  (num),
    .quotient_o (quo_i),
    .done_o     (div_done_i)
  );

  prca_div #(.DVW(DVW), .NW(NUM_W)) u_div_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_q),
    .divisor_i  (num),
    .quotient_o (quo_q),
    .done_o     (div_done_q)
  );

  logic signed [RW-1:0] qi_t, qq_t;
  assign qi_t = RW'(quo_i);
  assign qq_t = RW'(quo_q);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fadd_q      <= '0;
      idx_q       <= '0;
      saz_i_q     <= '0;
      saz_q_q     <= '0;
      phase_q     <= '0;
      fcnt_q      <= '0;
      act_q       <= ACT_STORE;
      step_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            xi_q    <= in_si;
            xq_q    <= in_sq;
            fr_i_q  <= in_fr_i;
            fr_q_q  <= in_fr_q;
            byp_q   <= bypass;
            last_q  <= last_d;
            slot_q  <= idx_q;
            act_q   <= act_d;
            fadd_q  <= fadd_d;
            phase_q <= phase_d;
            if (restart) begin
              saz_i_q <= in_az_i;
              saz_q_q <= in_az_q;
            end
            idx_q <= last_d ? '0 : idx_q + 1'b1;
            if (first) begin
              cx_q    <= CORD_X0;
              cy_q    <= '0;
              cz_q    <= {rr[31], rr};
              quad_q  <= quad0;
              step_q  <= '0;
              state_q <= S_TRIG;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_TRIG: begin
          if (!cz_q[CORD_W-1]) begin
            cx_q <= cx_q - dx;
            cy_q <= cy_q + dy;
            cz_q <= cz_q - atn;
          end else begin
            cx_q <= cx_q + dx;
            cy_q <= cy_q - dy;
            cz_q <= cz_q + atn;
          end
          step_q <= step_q + 1'b1;
          if (step_q == 4'(CORD_N - 1)) begin
            state_q <= S_TRIGFIN;
          end
        end
        S_TRIGFIN: begin
          cos_q   <= c_f;
          sin_q   <= s_f;
          state_q <= S_MUL;
        end
        S_MUL: begin
          pic_q   <= xi_q * cos_q;
          pqs_q   <= xq_q * sin_q;
          pqc_q   <= xq_q * cos_q;
          pis_q   <= xi_q * sin_q;
          state_q <= S_ROT;
        end
        S_ROT: begin
          ri_q    <= rsum_i[RW+14:15];
          rq_q    <= rsum_q[RW+14:15];
          state_q <= S_ACC;
        end
        S_ACC: begin
          olast_q <= last_q;
          if (byp_q) begin
            oi_q    <= ri_q;
            oq_q    <= rq_q;
            fn_i_q  <= fr_i_q;
            fn_q_q  <= fr_q_q;
            state_q <= S_OUT;
          end else begin
            fn_i_q <= fcnt_q;
            fn_q_q <= fcnt_q + 1'b1;
            if (act_q == ACT_LAST || act_q == ACT_MISMATCH) begin
              neg_i_q     <= avs_i[SUM_W-1];
              neg_q_q     <= avs_q[SUM_W-1];
              nzero_q     <= (num == '0);
              state_q     <= S_DIV;
            end else begin
              state_q <= S_IDLE;
            end
          end
          // frame end bookkeeping
          if (last_q) begin
            if (byp_q) begin
              fadd_q  <= '0;
              phase_q <= phase_q + pstep_q;
            end else if (act_q == ACT_STORE || act_q == ACT_ACCUM) begin
              fadd_q  <= fadd_q + 1'b1;
              phase_q <= phase_q + pstep_q;
            end else begin
              fadd_q  <= '0;
              phase_q <= '0;
              fcnt_q  <= fcnt_q + TAG_W'(2);
            end
          end
        end
        S_DIV: begin
          if (div_done_i) begin
            oi_q    <= nzero_q ? '0 : (neg_i_q ? -qi_t : qi_t);
            oq_q    <= nzero_q ? '0 : (neg_q_q ? -qq_t : qq_t);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output beat
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {{OPAD{1'b0}}, fn_q_q, fn_i_q, oq_q, oi_q};

  // Checks
  `ASSERT_CLK(a_one_in_flight, clk_i, rst_ni, !(s_axis_tready_o && m_axis_tvalid_o), "input taken while result pending")
  `ASSERT_NXT(a_accept_blocks, clk_i, rst_ni, accept, !s_axis_tready_o, "second beat taken without interlock")
  `ASSERT_IMP(a_no_bypass_write, clk_i, rst_ni, ram_we, !byp_q, "sum memory written in pass mode")
  `ASSERT_IMP(a_div_pair, clk_i, rst_ni, div_done_i, div_done_q, "dividers out of step")

endmodule
